>>> design/sgi_pkg.sv
`timescale 1ns / 1ps
// Package for segment_intersection: payload structs, widths and pipeline stage types.
// No dependencies.
package sgi_pkg;

  localparam int CW   = 16;        // coordinate width
  localparam int DW   = CW + 1;    // difference width
  localparam int PW   = 2 * DW;    // product width
  localparam int DETW = PW + 1;    // determinant / numerator width (signed)
  localparam int TW   = 2 * CW + 3; // threshold width
  localparam int DV   = PW;        // unsigned |det| width
  localparam int MW   = DV + DW;   // np * |d1| width
  localparam int NW   = MW + 1;    // dividend width after rounding bias
  localparam int QW   = DW;        // quotient width

  typedef struct packed {
    logic signed [CW-1:0] first_start_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_end_y;
    logic                 inclusive;
  } seg_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } seg_out_t;

  typedef struct packed {
    logic [DV-1:0] rem;
    logic [QW-1:0] num_lo;
    logic [QW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic          valid;
    logic          hit;
    logic          neg_x;
    logic          neg_y;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [DV-1:0] den;
  } div_side_t;

endpackage

>>> design/segment_intersection.sv
`timescale 1ns / 1ps
// Pipeline from input transaction to result register: 6 arithmetic stages,
// 17 divider stages, 1 output stage. Throughput: one transaction per cycle when not stalled.
// The whole pipeline stalls together while a result waits on out_ready.
// Reset (rst_n low, synchronous) clears all valid bits and sets the threshold thr_r to 1.
// Uses sgi_pkg.
module segment_intersection (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sgi_pkg::seg_in_t      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sgi_pkg::seg_out_t     out_data,
  input  logic                  cfg_we,
  input  logic [sgi_pkg::TW-1:0] cfg_data
);
  import sgi_pkg::*;

  logic          en;
  logic [TW-1:0] thr_r;

  // stage 1
  logic                 v1_r, incl1_r;
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, wx_r, wy_r;
  logic [CW-1:0]        ax1_r, ay1_r;
  // stage 2
  logic                 v2_r, incl2_r;
  logic signed [PW-1:0] p_a_r, p_b_r, p_c_r, p_d_r, p_e_r, p_f_r;
  logic signed [DW-1:0] d1x2_r, d1y2_r;
  logic [CW-1:0]        ax2_r, ay2_r;
  // stage 3
  logic                   v3_r, incl3_r;
  logic signed [DETW-1:0] det_r, np_r, nq_r;
  logic signed [DW-1:0]   d1x3_r, d1y3_r;
  logic [CW-1:0]          ax3_r, ay3_r;
  // stage 4
  logic                 v4_r, hit4_r;
  logic [DV-1:0]        den4_r, np4_r;
  logic signed [DW-1:0] d1x4_r, d1y4_r;
  logic [CW-1:0]        ax4_r, ay4_r;
  // stage 5
  logic          v5_r, hit5_r, negx5_r, negy5_r;
  logic [DV-1:0] den5_r;
  logic [MW-1:0] mx5_r, my5_r;
  logic [CW-1:0] ax5_r, ay5_r;

  div_lane_t lx_r [QW+1];
  div_lane_t ly_r [QW+1];
  div_side_t sd_r [QW+1];

  logic     out_valid_r;
  seg_out_t out_data_r;

  assign en        = ~out_valid_r | out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= TW'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // stage 4 combinational tests
  logic                   neg4;
  logic signed [DETW-1:0] detn, npn, nqn;
  logic [DV-1:0]          dmag;
  logic                   ok_p, ok_q, par;
  always_comb begin
    neg4 = det_r[DETW-1];
    detn = neg4 ? -det_r : det_r;
    npn  = neg4 ? -np_r : np_r;
    nqn  = neg4 ? -nq_r : nq_r;
    dmag = detn[DV-1:0];
    par  = (det_r == '0) || ({1'b0, dmag} < thr_r);
    if (incl3_r) begin
      ok_p = !npn[DETW-1] && (npn <= detn);
      ok_q = !nqn[DETW-1] && (nqn <= detn);
    end else begin
      ok_p = !npn[DETW-1] && (npn != '0) && (npn < detn);
      ok_q = !nqn[DETW-1] && (nqn != '0) && (nqn < detn);
    end
  end

  logic signed [DW-1:0] d1x4n, d1y4n;
  logic [DW-1:0]        mag_x, mag_y;
  logic [NW-1:0]        nx, ny;
  assign d1x4n = -d1x4_r;
  assign d1y4n = -d1y4_r;
  assign mag_x = d1x4_r[DW-1] ? d1x4n : d1x4_r;
  assign mag_y = d1y4_r[DW-1] ? d1y4n : d1y4_r;
  assign nx    = {1'b0, mx5_r} + NW'(den5_r >> 1);
  assign ny    = {1'b0, my5_r} + NW'(den5_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      sd_r[0].valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      sd_r[0].valid <= v5_r;

      d1x_r   <= DW'(in_data.first_end_x) - DW'(in_data.first_start_x);
      d1y_r   <= DW'(in_data.first_end_y) - DW'(in_data.first_start_y);
      d2x_r   <= DW'(in_data.second_end_x) - DW'(in_data.second_start_x);
      d2y_r   <= DW'(in_data.second_end_y) - DW'(in_data.second_start_y);
      wx_r    <= DW'(in_data.first_start_x) - DW'(in_data.second_start_x);
      wy_r    <= DW'(in_data.first_start_y) - DW'(in_data.second_start_y);
      ax1_r   <= in_data.first_start_x;
      ay1_r   <= in_data.first_start_y;
      incl1_r <= in_data.inclusive;

      p_a_r   <= PW'(d2x_r) * PW'(d1y_r);
      p_b_r   <= PW'(d2y_r) * PW'(d1x_r);
      p_c_r   <= PW'(wx_r) * PW'(d2y_r);
      p_d_r   <= PW'(wy_r) * PW'(d2x_r);
      p_e_r   <= PW'(wx_r) * PW'(d1y_r);
      p_f_r   <= PW'(wy_r) * PW'(d1x_r);
      d1x2_r  <= d1x_r;
      d1y2_r  <= d1y_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      incl2_r <= incl1_r;

      det_r   <= DETW'(p_a_r) - DETW'(p_b_r);
      np_r    <= DETW'(p_c_r) - DETW'(p_d_r);
      nq_r    <= DETW'(p_e_r) - DETW'(p_f_r);
      d1x3_r  <= d1x2_r;
      d1y3_r  <= d1y2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      incl3_r <= incl2_r;

      hit4_r  <= !par && ok_p && ok_q;
      den4_r  <= dmag;
      np4_r   <= npn[DV-1:0];
      d1x4_r  <= d1x3_r;
      d1y4_r  <= d1y3_r;
      ax4_r   <= ax3_r;
      ay4_r   <= ay3_r;

      mx5_r   <= MW'(np4_r) * MW'(mag_x);
      my5_r   <= MW'(np4_r) * MW'(mag_y);
      negx5_r <= d1x4_r[DW-1];
      negy5_r <= d1y4_r[DW-1];
      hit5_r  <= hit4_r;
      den5_r  <= den4_r;
      ax5_r   <= ax4_r;
      ay5_r   <= ay4_r;

      lx_r[0].rem    <= nx[NW-1-1:QW];
      lx_r[0].num_lo <= nx[QW-1:0];
      lx_r[0].quo    <= '0;
      ly_r[0].rem    <= ny[NW-1-1:QW];
      ly_r[0].num_lo <= ny[QW-1:0];
      ly_r[0].quo    <= '0;
      sd_r[0].hit    <= hit5_r;
      sd_r[0].neg_x  <= negx5_r;
      sd_r[0].neg_y  <= negy5_r;
      sd_r[0].ax     <= ax5_r;
      sd_r[0].ay     <= ay5_r;
      sd_r[0].den    <= den5_r;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DV:0] tx, ty, sx, sy;
    logic        bx, by;
    always_comb begin
      tx = {lx_r[k].rem, lx_r[k].num_lo[QW-1]};
      ty = {ly_r[k].rem, ly_r[k].num_lo[QW-1]};
      bx = tx >= {1'b0, sd_r[k].den};
      by = ty >= {1'b0, sd_r[k].den};
      sx = bx ? tx - {1'b0, sd_r[k].den} : tx;
      sy = by ? ty - {1'b0, sd_r[k].den} : ty;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[k+1].valid <= 1'b0;
      end else if (en) begin
        sd_r[k+1].valid  <= sd_r[k].valid;
        lx_r[k+1].rem    <= sx[DV-1:0];
        lx_r[k+1].num_lo <= lx_r[k].num_lo << 1;
        lx_r[k+1].quo    <= {lx_r[k].quo[QW-2:0], bx};
        ly_r[k+1].rem    <= sy[DV-1:0];
        ly_r[k+1].num_lo <= ly_r[k].num_lo << 1;
        ly_r[k+1].quo    <= {ly_r[k].quo[QW-2:0], by};
        sd_r[k+1].hit    <= sd_r[k].hit;
        sd_r[k+1].neg_x  <= sd_r[k].neg_x;
        sd_r[k+1].neg_y  <= sd_r[k].neg_y;
        sd_r[k+1].ax     <= sd_r[k].ax;
        sd_r[k+1].ay     <= sd_r[k].ay;
        sd_r[k+1].den    <= sd_r[k].den;
      end
    end
  end

  logic [CW-1:0] qx, qy;
  seg_out_t      res_nxt;
  always_comb begin
    qx = lx_r[QW].quo[CW-1:0];
    qy = ly_r[QW].quo[CW-1:0];
    res_nxt.hit     = sd_r[QW].hit;
    res_nxt.cross_x = '0;
    res_nxt.cross_y = '0;
    if (sd_r[QW].hit) begin
      res_nxt.cross_x = sd_r[QW].ax + (sd_r[QW].neg_x ? -qx : qx);
      res_nxt.cross_y = sd_r[QW].ay + (sd_r[QW].neg_y ? -qy : qy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sd_r[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

endmodule
